// ----- src/cqd_pkg.sv -----
// Shared constants for the packed quaternion decoder.
// Used by the core, the root lane and the testbench.
package cqd_pkg;

  localparam int NW = 40;
  localparam int QW = 32;
  localparam int RW = 16;
  localparam int CODE_W = 11;
  localparam int ZCODE_W = 10;

  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES = QW / DIV_PER_STAGE;
  localparam int SQRT_PER_STAGE = 4;
  localparam int SQRT_STAGES = RW / SQRT_PER_STAGE;
  localparam int LANE_LAT = 1 + DIV_STAGES + SQRT_STAGES;

  localparam logic [NW-1:0] SQ_1023 = 40'd1046529;
  localparam logic [NW-1:0] SQ_511 = 40'd261121;
  localparam logic [NW-1:0] DEN = 40'd273270699009;

  localparam logic [CODE_W-1:0] XY_MID = 11'd1023;
  localparam logic [ZCODE_W-1:0] Z_MID = 10'd511;

endpackage

// ----- src/cqd_root_lane.sv -----
// Pipelined rounded root of a ratio: floor(sqrt(n/d) * 2^FRAC_BITS + 1/2), capped at 32768.
// Restoring divider followed by a digit-by-digit square root; depends on cqd_pkg.
module cqd_root_lane #(
  parameter int FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [cqd_pkg::NW-1:0]  n,
  input  logic [cqd_pkg::NW-1:0]  d,
  output logic [cqd_pkg::RW-1:0]  mag
);

  localparam int NW = cqd_pkg::NW;
  localparam int QW = cqd_pkg::QW;
  localparam int RW = cqd_pkg::RW;
  localparam int DS = cqd_pkg::DIV_STAGES;
  localparam int DP = cqd_pkg::DIV_PER_STAGE;
  localparam int SS = cqd_pkg::SQRT_STAGES;
  localparam int SP = cqd_pkg::SQRT_PER_STAGE;
  localparam int SH = 2 * FRAC_BITS + 2;
  localparam int EW = NW + SH;
  localparam int HW = EW - QW;
  localparam int CW = (HW > NW) ? HW : NW;
  localparam int SRW = RW + 4;

  logic [EW-1:0] e;
  logic [CW-1:0] hi_ext;
  logic          sat0;

  assign e      = {n, {SH{1'b0}}};
  assign hi_ext = CW'(e[EW-1:QW]);
  assign sat0   = hi_ext >= CW'(d);

  logic [NW-1:0] dr   [0:DS];
  logic [NW-1:0] rem  [0:DS];
  logic [QW-1:0] lo   [0:DS];
  logic [QW-1:0] quo  [0:DS];
  logic          sat  [0:DS];

  always_ff @(posedge clk) begin
    if (en) begin
      dr[0]  <= d;
      rem[0] <= sat0 ? '0 : hi_ext[NW-1:0];
      lo[0]  <= e[QW-1:0];
      quo[0] <= '0;
      sat[0] <= sat0;
    end
  end

  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [NW-1:0] r_n;
    logic [QW-1:0] l_n;
    logic [QW-1:0] q_n;

    always_comb begin
      logic [NW:0] r2;
      r_n = rem[k];
      l_n = lo[k];
      q_n = quo[k];
      for (int i = 0; i < DP; i++) begin
        r2  = {r_n, l_n[QW-1]};
        l_n = {l_n[QW-2:0], 1'b0};
        if (r2 >= {1'b0, dr[k]}) begin
          r_n = NW'(r2 - {1'b0, dr[k]});
          q_n = {q_n[QW-2:0], 1'b1};
        end else begin
          r_n = r2[NW-1:0];
          q_n = {q_n[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr[k+1]  <= dr[k];
        rem[k+1] <= r_n;
        lo[k+1]  <= l_n;
        quo[k+1] <= q_n;
        sat[k+1] <= sat[k];
      end
    end
  end

  logic [SRW-1:0] srem [0:SS];
  logic [RW-1:0]  root [0:SS];
  logic [QW-1:0]  qb   [0:SS];

  assign srem[0] = '0;
  assign root[0] = '0;
  assign qb[0]   = sat[DS] ? '1 : quo[DS];

  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    logic [SRW-1:0] r_n;
    logic [RW-1:0]  t_n;
    logic [QW-1:0]  b_n;

    always_comb begin
      logic [SRW-1:0] trial;
      r_n = srem[k];
      t_n = root[k];
      b_n = qb[k];
      for (int i = 0; i < SP; i++) begin
        r_n   = {r_n[SRW-3:0], b_n[QW-1:QW-2]};
        b_n   = {b_n[QW-3:0], 2'b00};
        trial = SRW'({t_n, 2'b01});
        if (r_n >= trial) begin
          r_n = r_n - trial;
          t_n = {t_n[RW-2:0], 1'b1};
        end else begin
          t_n = {t_n[RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srem[k+1] <= r_n;
        root[k+1] <= t_n;
        qb[k+1]   <= b_n;
      end
    end
  end

  logic [RW:0] rounded;

  assign rounded = ({1'b0, root[SS]} + (RW+1)'(1)) >> 1;
  assign mag     = rounded[RW-1:0];

endmodule

// ----- src/compressed_quaternion_decode_core.sv -----
// Channel      Bus   Width  Contents
// s_axis       in    32     packed_word (x code, y code, z code from bit 0)
// m_axis       out   64+1   quat_x, quat_y, quat_z, quat_w; tuser was_normalized
// One request enters per cycle unless the output stalls. Four root lanes each hold a
// 32-step divider and 16-step root, between the front and the output registers.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears the valid bits only; data registers are not reset.
// Top level of the packed quaternion decoder; depends on cqd_pkg and cqd_root_lane.
module compressed_quaternion_decode_core #(
  parameter int FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // packed_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic [0:0]  m_axis_tuser    // was_normalized
);

  localparam int NW = cqd_pkg::NW;
  localparam int RW = cqd_pkg::RW;
  localparam int LL = cqd_pkg::LANE_LAT;
  localparam int CW = cqd_pkg::CODE_W;
  localparam int ZW = cqd_pkg::ZCODE_W;

  typedef struct packed {
    logic v;
    logic nx;
    logic ny;
    logic nz;
    logic norm;
  } side_t;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [CW-1:0] ca;
  logic [CW-1:0] cb;
  logic [ZW-1:0] cc;
  assign ca = s_axis_tdata[10:0];
  assign cb = s_axis_tdata[21:11];
  assign cc = s_axis_tdata[31:22];

  logic v1, v2, v3, v4, v5;
  logic nx1, ny1, nz1, nx2, ny2, nz2, nx3, ny3, nz3, nx4, ny4, nz4, nx5, ny5, nz5;
  logic [CW-1:0]   mx1, my1;
  logic [ZW-1:0]   mz1;
  logic [2*CW-1:0] sx2, sy2;
  logic [2*ZW-1:0] sz2;
  logic [NW-1:0]   xn3, yn3, zn3;
  logic [NW-1:0]   xn4, yn4, zn4, num4;
  logic [NW-1:0]   xn5, yn5, zn5, d5, wn5;
  logic            norm5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx1 <= ca[CW-1];
      ny1 <= cb[CW-1];
      nz1 <= cc[ZW-1];
      mx1 <= ca[CW-1] ? ca - cqd_pkg::XY_MID : cqd_pkg::XY_MID - ca;
      my1 <= cb[CW-1] ? cb - cqd_pkg::XY_MID : cqd_pkg::XY_MID - cb;
      mz1 <= cc[ZW-1] ? cc - cqd_pkg::Z_MID : cqd_pkg::Z_MID - cc;

      {nx2, ny2, nz2} <= {nx1, ny1, nz1};
      sx2 <= mx1 * mx1;
      sy2 <= my1 * my1;
      sz2 <= mz1 * mz1;

      {nx3, ny3, nz3} <= {nx2, ny2, nz2};
      xn3 <= NW'(NW'(sx2) * cqd_pkg::SQ_511);
      yn3 <= NW'(NW'(sy2) * cqd_pkg::SQ_511);
      zn3 <= NW'(NW'(sz2) * cqd_pkg::SQ_1023);

      {nx4, ny4, nz4} <= {nx3, ny3, nz3};
      {xn4, yn4, zn4} <= {xn3, yn3, zn3};
      num4 <= xn3 + yn3 + zn3;

      {nx5, ny5, nz5} <= {nx4, ny4, nz4};
      {xn5, yn5, zn5} <= {xn4, yn4, zn4};
      norm5 <= num4 >= cqd_pkg::DEN;
      d5    <= (num4 >= cqd_pkg::DEN) ? num4 : cqd_pkg::DEN;
      wn5   <= (num4 >= cqd_pkg::DEN) ? '0 : cqd_pkg::DEN - num4;
    end
  end

  logic [RW-1:0] mag_x, mag_y, mag_z, mag_w;

  cqd_root_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk(clk), .en(en), .n(xn5), .d(d5), .mag(mag_x)
  );
  cqd_root_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk(clk), .en(en), .n(yn5), .d(d5), .mag(mag_y)
  );
  cqd_root_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk(clk), .en(en), .n(zn5), .d(d5), .mag(mag_z)
  );
  cqd_root_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_w (
    .clk(clk), .en(en), .n(wn5), .d(cqd_pkg::DEN), .mag(mag_w)
  );

  side_t side [0:LL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].nx   <= nx5;
      side[0].ny   <= ny5;
      side[0].nz   <= nz5;
      side[0].norm <= norm5;
      for (int k = 1; k < LL; k++) begin
        side[k].nx   <= side[k-1].nx;
        side[k].ny   <= side[k-1].ny;
        side[k].nz   <= side[k-1].nz;
        side[k].norm <= side[k-1].norm;
      end
    end
    if (rst) begin
      for (int k = 0; k < LL; k++) begin
        side[k].v <= 1'b0;
      end
    end else if (en) begin
      side[0].v <= v5;
      for (int k = 1; k < LL; k++) begin
        side[k].v <= side[k-1].v;
      end
    end
  end

  function automatic logic [RW-1:0] encode(input logic neg, input logic [RW-1:0] m);
    logic [RW-1:0] res;
    if (neg) begin
      res = RW'(~m + RW'(1));
    end else if (m[RW-1]) begin
      res = {1'b0, {(RW-1){1'b1}}};
    end else begin
      res = m;
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= side[LL-1].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {encode(1'b1, mag_w), encode(side[LL-1].nz, mag_z),
                       encode(side[LL-1].ny, mag_y), encode(side[LL-1].nx, mag_x)};
      m_axis_tuser <= side[LL-1].norm;
    end
  end

endmodule

// ----- src/cqd_checker.sv -----
// Port-level checks for the packed quaternion decoder, bound to the core.
// Sees only the core's ports; depends on nothing else.
module cqd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("request side not tied to output drain");

  a_w_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[63:48] == 16'd0)
    else $error("w not zero after rescale");

  a_w_sign: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[63] || m_axis_tdata[63:48] == 16'd0)
    else $error("w positive");

endmodule

bind compressed_quaternion_decode_core cqd_checker u_cqd_checker (.*);

// ----- sim/compressed_quaternion_decode_core_tb.sv -----
// Testbench for the packed quaternion decoder core: drives packed words, predicts each
// decoded quaternion with exact integer arithmetic and compares every result field.
// Depends on cqd_pkg and the compressed_quaternion_decode_core RTL.
module compressed_quaternion_decode_core_tb;

  localparam int FRAC = 14;
  localparam int LATENCY = 19;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic [15:0] qw;
    logic [15:0] qz;
    logic [15:0] qy;
    logic [15:0] qx;
    logic        norm;
  } quat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  quat_t  expected_quats[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_off = 0;
  longint cycles = 0;

  compressed_quaternion_decode_core #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round(sqrt(num/den) * 2^FRAC), capped at 32768
  function automatic logic [15:0] root_mag(logic [127:0] den, logic [127:0] num);
    logic [127:0] rhs;
    logic [127:0] odd;
    int lo;
    int hi;
    int mid;
    rhs = num << (2 * FRAC + 2);
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * mid - 1;
      if (odd * odd * den <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[16:0] > 17'd32767 && lo != 32768 ? 16'h7fff : lo[15:0];
  endfunction

  function automatic logic [15:0] to_fixed(bit neg, int unsigned mag);
    if (!neg) return mag > 32767 ? 16'h7fff : mag[15:0];
    return 16'((65536 - mag) & 16'hffff);
  endfunction

  function automatic quat_t decode_quat(logic [31:0] word);
    quat_t q;
    logic [127:0] a, b, c, mx, my, mz, sx, sy, sz, num;
    bit nx, ny, nz;
    a = word[10:0];
    b = word[21:11];
    c = word[31:22];
    nx = a > 1023;
    ny = b > 1023;
    nz = c > 511;
    mx = nx ? a - 1023 : 1023 - a;
    my = ny ? b - 1023 : 1023 - b;
    mz = nz ? c - 511 : 511 - c;
    sx = mx * mx;
    sy = my * my;
    sz = mz * mz;
    num = (sx + sy) * cqd_pkg::SQ_511 + sz * cqd_pkg::SQ_1023;
    q.norm = num >= cqd_pkg::DEN;
    if (q.norm) begin
      q.qx = to_fixed(nx, root_mag(num, sx * cqd_pkg::SQ_511));
      q.qy = to_fixed(ny, root_mag(num, sy * cqd_pkg::SQ_511));
      q.qz = to_fixed(nz, root_mag(num, sz * cqd_pkg::SQ_1023));
      q.qw = to_fixed(1'b1, 0);
    end else begin
      q.qx = to_fixed(nx, root_mag(cqd_pkg::SQ_1023, sx));
      q.qy = to_fixed(ny, root_mag(cqd_pkg::SQ_1023, sy));
      q.qz = to_fixed(nz, root_mag(cqd_pkg::SQ_511, sz));
      q.qw = to_fixed(1'b1, root_mag(cqd_pkg::DEN, cqd_pkg::DEN - num));
    end
    return q;
  endfunction

  task automatic send_word(logic [31:0] word);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_quats.insert(expected_quats.size(), decode_quat(word));
    @(negedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pack(int a, int b, int c);
    return {c[9:0], b[10:0], a[10:0]};
  endfunction

  task automatic test_directed;
    int codes[5] = '{0, 1023, 1024, 2047, 1};
    int zcodes[5] = '{0, 511, 512, 1023, 1};
    send_word(32'h0000_0000);
    send_word(32'hffff_ffff);
    send_word(pack(1023, 1023, 511));
    send_word(32'h5555_5555);
    send_word(32'haaaa_aaaa);
    foreach (codes[i]) send_word(pack(codes[i], codes[(i + 1) % 5], zcodes[(i + 2) % 5]));
    foreach (codes[i]) send_word(pack(codes[i], 1023, zcodes[i]));
    send_word(pack(300, 1023, 511));
    send_word(pack(1023, 1023, 0));
    send_word(pack(0, 0, 0));
    send_word(pack(2047, 2047, 1023));
  endtask

  task automatic test_random(int count);
    logic [31:0] w;
    repeat (count) begin
      if ($urandom_range(3) == 0) w = $urandom();
      else w = pack($urandom_range(600, 1446), $urandom_range(600, 1446), $urandom_range(300, 722));
      send_word(w);
    end
  endtask

  task automatic test_backpressure;
    hold_off = 200;
    test_random(60);
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    quat_t got;
    quat_t exp_q;
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tuser[0]};
      if (expected_quats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        exp_q = expected_quats.pop_front();
        if (got.qx !== exp_q.qx) begin
          errors++;
          $display("%0t: quat_x expected %h actual %h", $time, exp_q.qx, got.qx);
        end
        if (got.qy !== exp_q.qy) begin
          errors++;
          $display("%0t: quat_y expected %h actual %h", $time, exp_q.qy, got.qy);
        end
        if (got.qz !== exp_q.qz) begin
          errors++;
          $display("%0t: quat_z expected %h actual %h", $time, exp_q.qz, got.qz);
        end
        if (got.qw !== exp_q.qw) begin
          errors++;
          $display("%0t: quat_w expected %h actual %h", $time, exp_q.qw, got.qw);
        end
        if (got.norm !== exp_q.norm) begin
          errors++;
          $display("%0t: was_normalized expected %b actual %b", $time, exp_q.norm, got.norm);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    drain();
    test_random(200);
    send_idle_pct = 58;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 58;
    test_random(150);
    send_idle_pct = 31;
    recv_stall_pct = 31;
    test_random(150);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    test_random(50);
    drain();
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
